/* rtl/psb_pkg.sv */
// Package for the pool slot balancer: word types, opcodes, status codes
// and the command/status groups between controller and datapath. No dependencies.
package psb_pkg;

  localparam int PRIO_W    = 8;
  localparam int MAX_POOLS = 8;
  localparam int NPOOL_W   = 4;
  localparam int CFG_AW    = 4;
  localparam int CFG_DW    = 64;

  localparam logic [1:0] OP_ASSIGN  = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_STATUS  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_POOL   = 2'd1;
  localparam logic [1:0] ST_SLOT_FREE = 2'd2;
  localparam logic [1:0] ST_BAD_POOL  = 2'd3;

  localparam logic REG_PRIORITIES   = 1'b0;
  localparam logic REG_POOLS_IN_USE = 1'b1;

  typedef struct packed {
    logic [1:0] opcode;
    logic [2:0] pool_sel;
    logic [3:0] slot_sel;
    logic       pool_working;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status_code;
    logic [2:0] chosen_pool;
    logic [3:0] chosen_slot;
    logic [4:0] pool_fill;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic pool_step;
    logic slot_step;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_assign;
    logic n_zero;
    logic pool_last;
    logic found_nxt;
    logic slot_free;
    logic out_busy;
  } dp_stat_t;

endpackage

/* rtl/pool_slot_balancer.sv */
// Pool slot balancer top level: configuration registers, controller and datapath.
// Depends on psb_pkg, psb_ctrl and psb_dp.
//
// Usage: each word on in_data (valid/ready) is an assign, release or pool
// status request and yields exactly one result word on out_data (valid/ready).
// An assign scans the pools in use one per cycle for the lowest priority
// number (ties: smaller fill, then lower index), then probes slots one per
// cycle starting at that pool's fill count. The scan covers pools_in_use
// capped at POOLS. Release, status, an unused opcode and an assign with
// no pool in use skip the scan and the probe; an assign that finds no
// eligible pool skips the probe. One word is in work at a time; in_ready
// is high only while the block waits for a word, so it rises together with
// out_valid of the result.
// The result sits in an output register: the block takes the next word
// while it waits, and only holds at its last step when a second result is
// due and the receiver still stalls.
// Reset (rst_n low, synchronous) marks all pools down with all slots free,
// sets the priorities to 0 and pools_in_use to 1. Registers: priorities at
// byte address 0, pools_in_use at 8, on a 64-bit port with pready tied high.
module pool_slot_balancer #(
  parameter int POOLS = 8,
  parameter int SLOTS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  psb_pkg::in_word_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output psb_pkg::out_word_t          out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [psb_pkg::CFG_AW-1:0]  paddr,
  input  logic [psb_pkg::CFG_DW-1:0]  pwdata,
  output logic [psb_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);
  import psb_pkg::*;

  logic [CFG_DW-1:0]  prio_r;
  logic [NPOOL_W-1:0] npools_r;
  logic [NPOOL_W-1:0] n_act;
  logic               cfg_wr;
  ctrl_cmd_t          cmd;
  dp_stat_t           stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prio_r   <= '0;
      npools_r <= NPOOL_W'(1);
    end else if (cfg_wr) begin
      if (paddr[3] == REG_PRIORITIES) prio_r   <= pwdata;
      else                            npools_r <= pwdata[NPOOL_W-1:0];
    end
  end

  assign prdata = (paddr[3] == REG_POOLS_IN_USE) ? {{(CFG_DW-NPOOL_W){1'b0}}, npools_r}
                                                 : prio_r;

  assign n_act = (npools_r > NPOOL_W'(POOLS)) ? NPOOL_W'(POOLS) : npools_r;

  psb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  psb_dp #(
    .POOLS (POOLS),
    .SLOTS (SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .prio_cfg  (prio_r),
    .n_act     (n_act),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* rtl/psb_ctrl.sv */
// Controller state machine of the pool slot balancer.
// Depends on psb_pkg; drives the datapath psb_dp by command bits.
module psb_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  psb_pkg::dp_stat_t    stat,
  output psb_pkg::ctrl_cmd_t   cmd
);
  import psb_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_POOL   = 5'b00100,
    S_SLOT   = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.is_assign && !stat.n_zero) state_nxt = S_POOL;
        else                                state_nxt = S_DONE;
      end
      S_POOL: begin
        cmd.pool_step = 1'b1;
        if (stat.pool_last) state_nxt = stat.found_nxt ? S_SLOT : S_DONE;
      end
      S_SLOT: begin
        if (stat.slot_free) state_nxt = S_DONE;
        else                cmd.slot_step = 1'b1;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

/* rtl/psb_dp.sv */
// Datapath of the pool slot balancer: pool state, pool scan, slot probe,
// result register. Depends on psb_pkg; sequenced by psb_ctrl.
module psb_dp #(
  parameter int POOLS = 8,
  parameter int SLOTS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  psb_pkg::in_word_t            in_data,
  input  logic [psb_pkg::CFG_DW-1:0]   prio_cfg,
  input  logic [psb_pkg::NPOOL_W-1:0]  n_act,
  input  psb_pkg::ctrl_cmd_t           cmd,
  output psb_pkg::dp_stat_t            stat,
  output logic                         out_valid,
  input  logic                         out_ready,
  output psb_pkg::out_word_t           out_data
);
  import psb_pkg::*;

  localparam int PW = (POOLS > 1) ? $clog2(POOLS) : 1;
  localparam int SW = $clog2(SLOTS);
  localparam int FW = $clog2(SLOTS + 1);

  logic             up_r    [POOLS];
  logic [FW-1:0]    fill_r  [POOLS];
  logic [SLOTS-1:0] taken_r [POOLS];

  in_word_t         in_r;
  logic [PW-1:0]    cur_r, best_r;
  logic [PRIO_W-1:0] best_prio_r;
  logic [FW-1:0]    best_fill_r;
  logic             found_r;
  logic [SW-1:0]    slot_r;
  logic             out_valid_r;
  out_word_t        out_data_r;

  logic [PRIO_W-1:0] prio_a [MAX_POOLS];
  logic              up_rd;
  logic [FW-1:0]     fill_rd, fill_inc, fill_dec;
  logic [SLOTS-1:0]  taken_rd;
  logic [PRIO_W-1:0] prio_rd;
  logic              take, found_nxt;
  logic [PW-1:0]     best_nxt;
  logic [FW-1:0]     best_fill_nxt;
  logic              bad_pool, slot_held;
  logic [SW-1:0]     rel_ix;
  logic              wr_en, up_new;
  logic [FW-1:0]     fill_new;
  logic [SLOTS-1:0]  taken_new;
  out_word_t         res;

  for (genvar g = 0; g < MAX_POOLS; g++) begin : g_prio
    assign prio_a[g] = prio_cfg[PRIO_W*g +: PRIO_W];
  end

  assign up_rd    = up_r[cur_r];
  assign fill_rd  = fill_r[cur_r];
  assign taken_rd = taken_r[cur_r];
  assign prio_rd  = prio_a[3'(cur_r)];
  assign fill_inc = fill_rd + FW'(1);
  assign fill_dec = (fill_rd != '0) ? fill_rd - FW'(1) : fill_rd;

  // pool scan: eligible and better than the best so far
  assign take = up_rd && (fill_rd < SLOTS) &&
                (!found_r || (prio_rd < best_prio_r) ||
                 ((prio_rd == best_prio_r) && (fill_rd < best_fill_r)));
  assign found_nxt     = found_r | take;
  assign best_nxt      = take ? cur_r : best_r;
  assign best_fill_nxt = take ? fill_rd : best_fill_r;

  assign bad_pool  = ({1'b0, in_r.pool_sel} >= n_act);
  assign rel_ix    = SW'(in_r.slot_sel);
  assign slot_held = (in_r.slot_sel < SLOTS) && taken_rd[rel_ix];

  always_comb begin
    res       = '0;
    wr_en     = 1'b0;
    up_new    = up_rd;
    fill_new  = fill_rd;
    taken_new = taken_rd;
    case (in_r.opcode)
      OP_ASSIGN: begin
        if (found_r) begin
          taken_new       = taken_rd | ({{(SLOTS-1){1'b0}}, 1'b1} << slot_r);
          fill_new        = fill_inc;
          wr_en           = 1'b1;
          res.status_code = ST_OK;
          res.chosen_pool = 3'(cur_r);
          res.chosen_slot = 4'(slot_r);
          res.pool_fill   = 5'(fill_inc);
        end else begin
          res.status_code = ST_NO_POOL;
        end
      end
      OP_RELEASE: begin
        res.chosen_pool = in_r.pool_sel;
        res.chosen_slot = in_r.slot_sel;
        if (bad_pool) begin
          res.status_code = ST_BAD_POOL;
        end else if (!slot_held) begin
          res.status_code = ST_SLOT_FREE;
          res.pool_fill   = 5'(fill_rd);
        end else begin
          taken_new       = taken_rd & ~({{(SLOTS-1){1'b0}}, 1'b1} << rel_ix);
          fill_new        = fill_dec;
          wr_en           = 1'b1;
          res.status_code = ST_OK;
          res.pool_fill   = 5'(fill_dec);
        end
      end
      OP_STATUS: begin
        res.chosen_pool = in_r.pool_sel;
        if (bad_pool) begin
          res.status_code = ST_BAD_POOL;
        end else begin
          up_new          = in_r.pool_working;
          wr_en           = 1'b1;
          res.status_code = ST_OK;
          res.pool_fill   = 5'(fill_rd);
        end
      end
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < POOLS; k++) begin
        up_r[k]    <= 1'b0;
        fill_r[k]  <= '0;
        taken_r[k] <= '0;
      end
    end else if (cmd.commit && wr_en) begin
      up_r[cur_r]    <= up_new;
      fill_r[cur_r]  <= fill_new;
      taken_r[cur_r] <= taken_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      cur_r   <= '0;
    end else if (cmd.load) begin
      found_r <= 1'b0;
      cur_r   <= (in_data.opcode == OP_ASSIGN) ? '0 : PW'(in_data.pool_sel);
    end else if (cmd.pool_step) begin
      found_r <= found_nxt;
      cur_r   <= stat.pool_last ? best_nxt : cur_r + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) in_r <= in_data;
    if (cmd.pool_step) begin
      best_r      <= best_nxt;
      best_fill_r <= best_fill_nxt;
      best_prio_r <= take ? prio_rd : best_prio_r;
      slot_r      <= SW'(best_fill_nxt);
    end else if (cmd.slot_step) begin
      slot_r <= (slot_r == SW'(SLOTS - 1)) ? '0 : slot_r + SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)          out_valid_r <= 1'b0;
    else if (cmd.commit) out_valid_r <= 1'b1;
    else if (out_ready)  out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign stat.is_assign = (in_r.opcode == OP_ASSIGN);
  assign stat.n_zero    = (n_act == '0);
  assign stat.pool_last = (4'(cur_r) == n_act - 4'd1);
  assign stat.found_nxt = found_nxt;
  assign stat.slot_free = !taken_rd[slot_r];
  assign stat.out_busy  = out_valid_r && !out_ready;

endmodule
